// ===== rtl/rgbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbc_pkg: shared constants and types for the RGB / YPbPr converter
// Default sizes, register indexes, direction codes and divider flag type.
// ----------------------------------------------------------------------------
package rgbc_pkg;

    // default sizes
    localparam int COMP_WIDTH  = 16;
    localparam int WEIGHT_BITS = 16;

    // reset weights are given at 16 fractional bits and rescaled to WEIGHT_BITS
    localparam int REF_WEIGHT_BITS = 16;
    localparam int RED_RESET       = 19595;   // 0.299
    localparam int BLUE_RESET      = 7471;    // 0.114

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_RED  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE = 2'd1;

    // direction codes
    localparam logic CMD_TO_YPBPR = 1'b0;
    localparam logic CMD_TO_RGB   = 1'b1;

    // divider side flags
    typedef struct packed {
        logic neg;   // quotient is negative
        logic ovf;   // magnitude does not fit the quotient width
    } div_flags_t;

endpackage

// ===== rtl/rgbc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbc_if: pixel channels of the RGB / YPbPr converter
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rgbc_pix_in_if #(
    parameter int COMP_WIDTH = rgbc_pkg::COMP_WIDTH
);
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [COMP_WIDTH-1:0] in_first;
    logic signed [COMP_WIDTH-1:0] in_second;
    logic signed [COMP_WIDTH-1:0] in_third;

    modport source (output valid, cmd, in_first, in_second, in_third, input ready);
    modport sink   (input valid, cmd, in_first, in_second, in_third, output ready);
endinterface

interface rgbc_pix_out_if #(
    parameter int COMP_WIDTH = rgbc_pkg::COMP_WIDTH
);
    logic                         valid;
    logic                         ready;
    logic signed [COMP_WIDTH-1:0] out_first;
    logic signed [COMP_WIDTH-1:0] out_second;
    logic signed [COMP_WIDTH-1:0] out_third;
    logic                         clipped;
    logic                         weight_error;

    modport source (output valid, out_first, out_second, out_third, clipped,
                    weight_error, input ready);
    modport sink   (input valid, out_first, out_second, out_third, clipped,
                    weight_error, output ready);
endinterface

// ===== rtl/rgbc_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbc_divider: pipelined signed-by-unsigned divider, truncating toward zero
// One front stage takes sign, magnitude and overflow; then one restoring
// step per quotient bit. All stages advance only when en is high.
// ----------------------------------------------------------------------------
module rgbc_divider #(
    parameter int NUM_W = 51,
    parameter int DEN_W = 33,
    parameter int Q_W   = 16
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [NUM_W-1:0]   num,
    input  logic        [DEN_W-1:0]   den,
    output logic        [Q_W-1:0]     q_mag,
    output rgbc_pkg::div_flags_t      flags
);

    localparam int MAG_W = NUM_W - 1;

    logic [MAG_W-1:0]     rem_reg [Q_W+1];
    logic [DEN_W-1:0]     den_reg [Q_W+1];
    logic [Q_W-1:0]       quo_reg [Q_W+1];
    rgbc_pkg::div_flags_t flg_reg [Q_W+1];

    logic [MAG_W-1:0]        lim;
    logic signed [NUM_W-1:0] lim_s;
    logic signed [NUM_W-1:0] num_neg;
    logic [MAG_W-1:0]        mag_next;
    rgbc_pkg::div_flags_t    flg_next;

    // front stage: sign, magnitude, and overflow against den * 2^Q_W
    always_comb
    begin
        lim           = MAG_W'({den, {Q_W{1'b0}}});
        lim_s         = $signed({1'b0, lim});
        num_neg       = -num;
        flg_next.neg  = num[NUM_W-1];
        flg_next.ovf  = (num >= lim_s) || (num <= -lim_s);
        mag_next      = flg_next.neg ? num_neg[MAG_W-1:0] : num[MAG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= mag_next;
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            flg_reg[0] <= flg_next;
        end
    end

    // restoring steps, most significant quotient bit first
    for (genvar k = 1; k <= Q_W; k++)
    begin : g_step
        localparam int BIT = Q_W - k;
        logic [MAG_W-1:0] dsh;
        logic [MAG_W:0]   trial;

        always_comb
        begin
            dsh   = MAG_W'(den_reg[k-1]) << BIT;
            trial = {1'b0, rem_reg[k-1]} - {1'b0, dsh};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[k] <= den_reg[k-1];
                flg_reg[k] <= flg_reg[k-1];
                if (!trial[MAG_W])
                begin
                    rem_reg[k] <= trial[MAG_W-1:0];
                    quo_reg[k] <= quo_reg[k-1] | (Q_W'(1) << BIT);
                end
                else
                begin
                    rem_reg[k] <= rem_reg[k-1];
                    quo_reg[k] <= quo_reg[k-1];
                end
            end
        end
    end

    assign q_mag = quo_reg[Q_W];
    assign flags = flg_reg[Q_W];

endmodule

// ===== rtl/rgb_ypbpr_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_ypbpr_converter: per-pixel RGB <-> YPbPr conversion
// Programmable luma weights kr and kb; kg = 1 - kr - kb.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in carries one pixel and a direction bit (cmd); pix_out returns one
//   result item per input item, in order, with saturated components, a clip
//   flag and a weight error flag (kr + kb >= 1 gives zero components).
//   cfg_we / cfg_index / cfg_data write kr (index 0) and kb (index 1); write
//   them only while no items are in flight.
//   The pipeline is three multiply/add stages, the divider's front stage
//   plus one stage per quotient bit, and the output register. The quotient
//   pipeline sets its depth.
//   Throughput is one item per cycle, sustained while pix_out.ready stays high.
//   Reset clears all valid bits and loads the BT.601 weights.
//   When the receiver holds ready low with a result waiting, the whole
//   pipeline holds; pix_in.ready follows, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rgb_ypbpr_converter #(
    parameter int COMP_WIDTH  = rgbc_pkg::COMP_WIDTH,
    parameter int WEIGHT_BITS = rgbc_pkg::WEIGHT_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    rgbc_pix_in_if.sink                        pix_in,
    rgbc_pix_out_if.source                     pix_out,
    input  logic                               cfg_we,
    input  logic [rgbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [WEIGHT_BITS-1:0]             cfg_data
);

    localparam int C   = COMP_WIDTH;
    localparam int W   = WEIGHT_BITS;
    localparam int RW  = W + C + 2;        // products, scaled R / B / Y
    localparam int GW  = 2 * W + C + 3;    // G numerator, divider numerators
    localparam int DW  = 2 * W + 1;        // divider denominators
    localparam int TW  = C + 2;            // truncated shift quotients
    localparam int LAT = C + 1;            // divider register depth

    localparam int RSH = (W >= rgbc_pkg::REF_WEIGHT_BITS) ?
                         W - rgbc_pkg::REF_WEIGHT_BITS : 0;
    localparam int LSH = (W < rgbc_pkg::REF_WEIGHT_BITS) ?
                         rgbc_pkg::REF_WEIGHT_BITS - W : 0;
    localparam longint unsigned RED_RST_L  = (longint'(rgbc_pkg::RED_RESET) << RSH) >> LSH;
    localparam longint unsigned BLUE_RST_L = (longint'(rgbc_pkg::BLUE_RESET) << RSH) >> LSH;
    localparam logic [W-1:0] RED_RST  = RED_RST_L[W-1:0];
    localparam logic [W-1:0] BLUE_RST = BLUE_RST_L[W-1:0];

    localparam logic signed [C-1:0] CMAX = {1'b0, {(C-1){1'b1}}};
    localparam logic signed [C-1:0] CMIN = {1'b1, {(C-1){1'b0}}};

    // ------------------------------------------------------------------
    // weight registers and derived constants
    // ------------------------------------------------------------------
    logic [W-1:0]      kr_reg, kb_reg;
    logic signed [W+1:0] kg;
    logic [W:0]        dr, db;          // 1 - kr, 1 - kb
    logic              err_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kr_reg <= RED_RST;
            kb_reg <= BLUE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rgbc_pkg::REG_RED:  kr_reg <= cfg_data;
                rgbc_pkg::REG_BLUE: kb_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        kg      = $signed({2'b01, {W{1'b0}}}) - $signed({2'b00, kr_reg})
                  - $signed({2'b00, kb_reg});
        err_now = kg[W+1] || (kg == '0);
        dr      = {1'b1, {W{1'b0}}} - {1'b0, kr_reg};
        db      = {1'b1, {W{1'b0}}} - {1'b0, kb_reg};
    end

    // ------------------------------------------------------------------
    // pipeline control: every stage moves when the output can move
    // ------------------------------------------------------------------
    logic adv;
    logic v1_reg, v2_reg, v3_reg, out_vld_reg;
    logic dv_reg [LAT];

    assign adv          = !out_vld_reg || pix_out.ready;
    assign pix_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < LAT; i++)
                dv_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= pix_in.valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            dv_reg[0] <= v3_reg;
            for (int i = 1; i < LAT; i++)
                dv_reg[i] <= dv_reg[i-1];
            out_vld_reg <= dv_reg[LAT-1];
        end
    end

    // ------------------------------------------------------------------
    // stage 1: first products (forward weights, or scaled R and B)
    // ------------------------------------------------------------------
    logic                 s1_cmd_reg, s1_err_reg;
    logic signed [C-1:0]  s1_a_reg, s1_c_reg;
    logic signed [RW-1:0] s1_m0_reg, s1_m1_reg, s1_m2_reg;
    logic signed [RW-1:0] s1_m0_next, s1_m1_next, s1_m2_next;
    logic signed [RW-1:0] fa, fb, fc;

    always_comb
    begin
        fa = RW'(pix_in.in_first);
        fb = RW'(pix_in.in_second);
        fc = RW'(pix_in.in_third);
        s1_m2_next = RW'($signed({1'b0, kb_reg})) * fc;
        if (pix_in.cmd == rgbc_pkg::CMD_TO_RGB)
        begin
            s1_m0_next = (fa <<< W) + RW'($signed({1'b0, dr, 1'b0})) * fc;
            s1_m1_next = (fa <<< W) + RW'($signed({1'b0, db, 1'b0})) * fb;
        end
        else
        begin
            s1_m0_next = RW'($signed({1'b0, kr_reg})) * fa;
            s1_m1_next = RW'(kg) * fb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg <= pix_in.cmd;
            s1_err_reg <= err_now;
            s1_a_reg   <= pix_in.in_first;
            s1_c_reg   <= pix_in.in_third;
            s1_m0_reg  <= s1_m0_next;
            s1_m1_reg  <= s1_m1_next;
            s1_m2_reg  <= s1_m2_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: luma sum, or weighted R and B for the G numerator
    // ------------------------------------------------------------------
    logic                 s2_cmd_reg, s2_err_reg;
    logic signed [C-1:0]  s2_a_reg, s2_c_reg;
    logic signed [RW-1:0] s2_x_reg, s2_y_reg;
    logic signed [GW-1:0] s2_g1_reg, s2_g2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_cmd_reg <= s1_cmd_reg;
            s2_err_reg <= s1_err_reg;
            s2_a_reg   <= s1_a_reg;
            s2_c_reg   <= s1_c_reg;
            s2_x_reg   <= (s1_cmd_reg == rgbc_pkg::CMD_TO_RGB) ? s1_m0_reg :
                          s1_m0_reg + s1_m1_reg + s1_m2_reg;
            s2_y_reg   <= s1_m1_reg;
            s2_g1_reg  <= GW'($signed({1'b0, kb_reg})) * GW'(s1_m1_reg);
            s2_g2_reg  <= GW'($signed({1'b0, kr_reg})) * GW'(s1_m0_reg);
        end
    end

    // ------------------------------------------------------------------
    // stage 3: divider numerators / denominators, shift quotients
    // ------------------------------------------------------------------
    logic                 s3_cmd_reg, s3_err_reg;
    logic signed [GW-1:0] s3_na_reg, s3_nb_reg;
    logic [DW-1:0]        s3_da_reg, s3_db_reg;
    logic signed [TW-1:0] s3_t1_reg, s3_t3_reg;
    logic signed [RW-1:0] bx, by;

    always_comb
    begin
        bx = s2_x_reg + $signed({{(C+2){1'b0}}, {W{s2_x_reg[RW-1]}}});
        by = s2_y_reg + $signed({{(C+2){1'b0}}, {W{s2_y_reg[RW-1]}}});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_cmd_reg <= s2_cmd_reg;
            s3_err_reg <= s2_err_reg;
            s3_t1_reg  <= bx[RW-1:W];
            s3_t3_reg  <= by[RW-1:W];
            s3_db_reg  <= DW'({dr, 1'b0});
            if (s2_cmd_reg == rgbc_pkg::CMD_TO_RGB)
            begin
                s3_na_reg <= (GW'(s2_a_reg) <<< (2 * W)) - s2_g1_reg - s2_g2_reg;
                s3_da_reg <= {kg[W:0], {W{1'b0}}};
            end
            else
            begin
                s3_na_reg <= (GW'(s2_c_reg) <<< W) - GW'(s2_x_reg);
                s3_da_reg <= DW'({db, 1'b0});
            end
            s3_nb_reg <= (GW'(s2_a_reg) <<< W) - GW'(s2_x_reg);
        end
    end

    // ------------------------------------------------------------------
    // dividers, and the side data that travels beside them
    // ------------------------------------------------------------------
    logic [C-1:0]         qa_mag, qb_mag;
    rgbc_pkg::div_flags_t qa_flg, qb_flg;

    rgbc_divider #(.NUM_W(GW), .DEN_W(DW), .Q_W(C)) u_div_a (
        .clk   (clk),
        .en    (adv),
        .num   (s3_na_reg),
        .den   (s3_da_reg),
        .q_mag (qa_mag),
        .flags (qa_flg)
    );

    rgbc_divider #(.NUM_W(GW), .DEN_W(DW), .Q_W(C)) u_div_b (
        .clk   (clk),
        .en    (adv),
        .num   (s3_nb_reg),
        .den   (s3_db_reg),
        .q_mag (qb_mag),
        .flags (qb_flg)
    );

    logic                 dcmd_reg [LAT];
    logic                 derr_reg [LAT];
    logic signed [TW-1:0] dt1_reg  [LAT];
    logic signed [TW-1:0] dt3_reg  [LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dcmd_reg[0] <= s3_cmd_reg;
            derr_reg[0] <= s3_err_reg;
            dt1_reg[0]  <= s3_t1_reg;
            dt3_reg[0]  <= s3_t3_reg;
            for (int i = 1; i < LAT; i++)
            begin
                dcmd_reg[i] <= dcmd_reg[i-1];
                derr_reg[i] <= derr_reg[i-1];
                dt1_reg[i]  <= dt1_reg[i-1];
                dt3_reg[i]  <= dt3_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // output stage: saturation and result register
    // ------------------------------------------------------------------
    logic signed [C-1:0] o1, o2, o3;
    logic                c1, c2, c3;
    logic signed [C-1:0] out_first_reg, out_second_reg, out_third_reg;
    logic                clipped_reg, werr_reg;

    // saturate divider quotients (magnitude, sign, overflow) and shift quotients
    always_comb
    begin
        if (qa_flg.neg)
        begin
            c2 = qa_flg.ovf || (qa_mag > {1'b1, {(C-1){1'b0}}});
            o2 = c2 ? CMIN : $signed(~qa_mag + C'(1));
        end
        else
        begin
            c2 = qa_flg.ovf || qa_mag[C-1];
            o2 = c2 ? CMAX : $signed(qa_mag);
        end

        c1 = (dt1_reg[LAT-1][TW-1:C-1] != '0) && (dt1_reg[LAT-1][TW-1:C-1] != '1);
        o1 = !c1 ? dt1_reg[LAT-1][C-1:0] : (dt1_reg[LAT-1][TW-1] ? CMIN : CMAX);

        if (dcmd_reg[LAT-1] == rgbc_pkg::CMD_TO_RGB)
        begin
            c3 = (dt3_reg[LAT-1][TW-1:C-1] != '0) && (dt3_reg[LAT-1][TW-1:C-1] != '1);
            o3 = !c3 ? dt3_reg[LAT-1][C-1:0] : (dt3_reg[LAT-1][TW-1] ? CMIN : CMAX);
        end
        else if (qb_flg.neg)
        begin
            c3 = qb_flg.ovf || (qb_mag > {1'b1, {(C-1){1'b0}}});
            o3 = c3 ? CMIN : $signed(~qb_mag + C'(1));
        end
        else
        begin
            c3 = qb_flg.ovf || qb_mag[C-1];
            o3 = c3 ? CMAX : $signed(qb_mag);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            werr_reg <= derr_reg[LAT-1];
            if (derr_reg[LAT-1])
            begin
                out_first_reg  <= '0;
                out_second_reg <= '0;
                out_third_reg  <= '0;
                clipped_reg    <= 1'b0;
            end
            else
            begin
                out_first_reg  <= o1;
                out_second_reg <= o2;
                out_third_reg  <= o3;
                clipped_reg    <= c1 || c2 || c3;
            end
        end
    end

    assign pix_out.valid        = out_vld_reg;
    assign pix_out.out_first    = out_first_reg;
    assign pix_out.out_second   = out_second_reg;
    assign pix_out.out_third    = out_third_reg;
    assign pix_out.clipped      = clipped_reg;
    assign pix_out.weight_error = werr_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && werr_reg |-> (out_first_reg == '0) && (out_second_reg == '0)
                                    && (out_third_reg == '0) && !clipped_reg)
        else $error("weight error result is not all zero");

    a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && clipped_reg |->
            (out_first_reg == CMAX) || (out_first_reg == CMIN) ||
            (out_second_reg == CMAX) || (out_second_reg == CMIN) ||
            (out_third_reg == CMAX) || (out_third_reg == CMIN))
        else $error("clip flag set but no component at a limit");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(dv_reg[LAT-1]))
        else $error("result appeared without an item in the last stage");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> pix_in.ready)
        else $error("input blocked while the output register is empty");

endmodule

// ===== test/tb_rgb_ypbpr_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_ypbpr_converter: self-checking bench for the RGB / YPbPr converter
// Feeds pixels in both directions under several luma weight settings (BT.601,
// BT.709, zero, extreme and invalid weights), with bursty input, random and
// long output stalls, and checks every result against a local predictor.
// ----------------------------------------------------------------------------
module tb_rgb_ypbpr_converter;

    localparam int  CW         = rgbc_pkg::COMP_WIDTH;
    localparam int  WB         = rgbc_pkg::WEIGHT_BITS;
    localparam int  LATENCY    = CW + 5;
    localparam int  IDLE_LIMIT = 5000;
    localparam longint ONE_W   = longint'(1) << WB;
    localparam longint CMAX    = (longint'(1) << (CW - 1)) - 1;
    localparam longint CMIN    = -CMAX - 1;

    typedef struct packed {
        logic          cmd;
        logic [CW-1:0] c1;
        logic [CW-1:0] c2;
        logic [CW-1:0] c3;
    } pixel_t;

    typedef struct packed {
        logic [CW-1:0] c1;
        logic [CW-1:0] c2;
        logic [CW-1:0] c3;
        logic          clip;
        logic          werr;
    } conv_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [rgbc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [WB-1:0] cfg_data;

    rgbc_pix_in_if  #(.COMP_WIDTH(CW)) pix_in ();
    rgbc_pix_out_if #(.COMP_WIDTH(CW)) pix_out ();

    rgb_ypbpr_converter #(.COMP_WIDTH(CW), .WEIGHT_BITS(WB)) dut (
        .clk(clk), .rst_n(rst_n), .pix_in(pix_in.sink), .pix_out(pix_out.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    pixel_t pending_pixels[$];
    conv_t  expected_pixels[$];
    logic [WB-1:0] kr_w;
    logic [WB-1:0] kb_w;
    int  errors;
    int  n_sent;
    int  n_checked;
    int  n_clipped;
    int  n_werr;
    int  idle_cycles;
    int  burst_left;
    int  gap_left;
    int  hold_left;
    bit  long_hold_req;
    bit  long_hold_done;
    bit  stall_on;
    bit  in_fire;

    // saturate one component
    function automatic logic [CW-1:0] saturate(input longint v, inout logic clip);
        if (v > CMAX)
        begin
            clip = 1'b1;
            return CMAX[CW-1:0];
        end
        if (v < CMIN)
        begin
            clip = 1'b1;
            return CMIN[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    // expected conversion under the current weights
    function automatic conv_t convert_pixel(input pixel_t p);
        conv_t  r;
        longint kr, kb, kg, a, b, c, ys, rs, bs, gnum, o1, o2, o3;
        logic   clip;
        kr = longint'(kr_w);
        kb = longint'(kb_w);
        kg = ONE_W - kr - kb;
        a  = longint'($signed(p.c1));
        b  = longint'($signed(p.c2));
        c  = longint'($signed(p.c3));
        clip = 1'b0;
        r = '0;
        if (kg <= 0)
        begin
            r.werr = 1'b1;
            return r;
        end
        if (p.cmd == rgbc_pkg::CMD_TO_YPBPR)
        begin
            ys = kr * a + kg * b + kb * c;
            o1 = ys / ONE_W;
            o2 = (c * ONE_W - ys) / (2 * (ONE_W - kb));
            o3 = (a * ONE_W - ys) / (2 * (ONE_W - kr));
        end
        else
        begin
            rs = a * ONE_W + 2 * (ONE_W - kr) * c;
            bs = a * ONE_W + 2 * (ONE_W - kb) * b;
            gnum = a * ONE_W * ONE_W - kb * bs - kr * rs;
            o1 = rs / ONE_W;
            o2 = gnum / (kg * ONE_W);
            o3 = bs / ONE_W;
        end
        r.c1 = saturate(o1, clip);
        r.c2 = saturate(o2, clip);
        r.c3 = saturate(o3, clip);
        r.clip = clip;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                   input logic [CW-1:0] want);
        errors++;
        $display("MISMATCH item %0d %s: got %0d want %0d", n_checked, what,
                 $signed(got), $signed(want));
    endtask

    // driver: bursts and gaps, valid held until accepted
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pix_in.valid <= 1'b0;
        end
        else if (pix_in.valid && !in_fire)
        begin
            // hold current item
        end
        else if (pending_pixels.size() == 0)
        begin
            pix_in.valid <= 1'b0;
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            pix_in.valid <= 1'b0;
        end
        else
        begin
            pix_in.valid     <= 1'b1;
            pix_in.cmd       <= pending_pixels[0].cmd;
            pix_in.in_first  <= pending_pixels[0].c1;
            pix_in.in_second <= pending_pixels[0].c2;
            pix_in.in_third  <= pending_pixels[0].c3;
            void'(pending_pixels.pop_front());
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(40);
                gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
            end
        end
    end

    // receiver stall pattern plus one long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pix_out.ready <= 1'b0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            if (hold_left == 0)
                hold_left = 200;
            else if (hold_left == 1)
                long_hold_done = 1'b1;
            hold_left--;
            pix_out.ready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(31) == 0)
                stall_on = !stall_on;
            pix_out.ready <= stall_on ? ($urandom_range(3) == 0) : ($urandom_range(7) != 0);
        end
    end

    // input monitor: predict on acceptance, and tell the driver
    always @(posedge clk)
    begin
        in_fire = rst_n && pix_in.valid && pix_in.ready;
        if (in_fire)
        begin
            expected_pixels.insert(expected_pixels.size(),
                                   convert_pixel({pix_in.cmd, pix_in.in_first,
                                                  pix_in.in_second, pix_in.in_third}));
            n_sent++;
        end
    end

    // output monitor and watchdog
    always @(posedge clk)
    begin
        conv_t want;
        if (rst_n)
        begin
            if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
            if (pix_out.valid && pix_out.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    $display("MISMATCH unexpected result item");
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pix_out.out_first !== want.c1)
                        report_mismatch("out_first", pix_out.out_first, want.c1);
                    if (pix_out.out_second !== want.c2)
                        report_mismatch("out_second", pix_out.out_second, want.c2);
                    if (pix_out.out_third !== want.c3)
                        report_mismatch("out_third", pix_out.out_third, want.c3);
                    if (pix_out.clipped !== want.clip)
                        report_mismatch("clipped", CW'(pix_out.clipped), CW'(want.clip));
                    if (pix_out.weight_error !== want.werr)
                        report_mismatch("weight_error", CW'(pix_out.weight_error),
                                        CW'(want.werr));
                    n_clipped += int'(want.clip);
                    n_werr    += int'(want.werr);
                end
                n_checked++;
            end
        end
    end

    function automatic logic [CW-1:0] rand_comp();
        case ($urandom_range(5))
            0: return CMAX[CW-1:0];
            1: return CMIN[CW-1:0];
            2: return CW'($urandom_range(16384));
            3: return -CW'($urandom_range(16384));
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic queue_pixel(input logic cmd, input logic [CW-1:0] a,
                               input logic [CW-1:0] b, input logic [CW-1:0] c);
        pending_pixels.insert(pending_pixels.size(), {cmd, a, b, c});
    endtask

    // wait until every item is sent and checked, then let the pipe drain
    task automatic drain();
        while (pending_pixels.size() != 0 || pix_in.valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_weights(input logic [WB-1:0] red, input logic [WB-1:0] blue);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_index <= rgbc_pkg::REG_RED; cfg_data <= red;
        @(negedge clk);
        cfg_index <= rgbc_pkg::REG_BLUE; cfg_data <= blue;
        @(negedge clk);
        cfg_we <= 1'b0;
        kr_w = red;
        kb_w = blue;
    endtask

    task automatic random_pixels(input int count);
        repeat (count)
            queue_pixel(1'($urandom_range(1)), rand_comp(), rand_comp(), rand_comp());
    endtask

    // stimulus
    initial
    begin
        logic [CW-1:0] mx, mn;
        mx = CMAX[CW-1:0];
        mn = CMIN[CW-1:0];
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        pix_in.valid = 1'b0; pix_in.cmd = 1'b0;
        pix_in.in_first = '0; pix_in.in_second = '0; pix_in.in_third = '0;
        pix_out.ready = 1'b0;
        kr_w = WB'(rgbc_pkg::RED_RESET); kb_w = WB'(rgbc_pkg::BLUE_RESET);
        errors = 0; n_sent = 0; n_checked = 0; n_clipped = 0; n_werr = 0;
        idle_cycles = 0; burst_left = 0; gap_left = 0; hold_left = 0;
        long_hold_req = 0; long_hold_done = 0; stall_on = 0; in_fire = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset weights, extremes in both directions
        for (int d = 0; d < 2; d++)
        begin
            queue_pixel(1'(d), '0, '0, '0);
            queue_pixel(1'(d), mx, mx, mx);
            queue_pixel(1'(d), mn, mn, mn);
            queue_pixel(1'(d), mx, mn, mx);
            queue_pixel(1'(d), mn, mx, mn);
            queue_pixel(1'(d), 16'sd16384, -16'sd16384, 16'sd8192);
            queue_pixel(1'(d), -16'sd1, 16'sd1, -16'sd1);
        end
        drain();

        // invalid weights (kr + kb = 1 and beyond)
        write_weights(16'd32768, 16'd32768);
        queue_pixel(rgbc_pkg::CMD_TO_YPBPR, mx, 16'sd100, mn);
        queue_pixel(rgbc_pkg::CMD_TO_RGB, mn, mx, 16'sd5);
        drain();
        write_weights(16'hFFFF, 16'hFFFF);
        queue_pixel(rgbc_pkg::CMD_TO_RGB, 16'sd1000, mx, mn);
        drain();

        // random phases over several weight settings, one long hold-off
        write_weights(WB'(rgbc_pkg::RED_RESET), WB'(rgbc_pkg::BLUE_RESET));
        long_hold_req = 1'b1;
        random_pixels(150);
        drain();
        write_weights(16'd13933, 16'd4732);       // BT.709
        random_pixels(150);
        drain();
        write_weights(16'd0, 16'd0);
        random_pixels(100);
        drain();
        write_weights(16'hFFFF, 16'd0);
        random_pixels(80);
        drain();
        write_weights(16'd0, 16'hFFFF);
        random_pixels(80);
        drain();
        write_weights(16'd1, 16'd1);
        random_pixels(60);
        drain();
        for (int k = 0; k < 4; k++)
        begin
            write_weights(WB'($urandom), WB'($urandom));
            random_pixels(40);
            drain();
        end

        $display("Checked %0d of %0d items, %0d clipped, %0d with bad weights.",
                 n_checked, n_sent, n_clipped, n_werr);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
